// File: src/rsd_pkg.sv
`default_nettype none

package rsd_pkg;

  // Parse phase of the relocation list.
  typedef enum logic [1:0] {
    PH_CTRL = 2'd0,
    PH_SKIP = 2'd1,
    PH_EXT1 = 2'd2,
    PH_EXT2 = 2'd3
  } phase_t;

  // Result kinds.
  localparam logic [2:0] KIND_TEXT   = 3'd0;
  localparam logic [2:0] KIND_DATA   = 3'd1;
  localparam logic [2:0] KIND_SYMBOL = 3'd2;
  localparam logic [2:0] KIND_END    = 3'd3;
  localparam logic [2:0] KIND_UNUSED = 3'd4;

  // Relocation codes, taken from (byte - 64) >> 2.
  localparam logic [5:0] CODE_UNUSED_LO = 6'd0;
  localparam logic [5:0] CODE_TEXT      = 6'd1;
  localparam logic [5:0] CODE_DATA      = 6'd2;
  localparam logic [5:0] CODE_UNUSED_HI = 6'd3;
  localparam logic [5:0] CODE_EXTENDED  = 6'd47;
  localparam logic [5:0] CODE_SYM_BASE  = 6'd4;

  // Control byte bounds and index offsets.
  localparam logic [7:0]  BYTE_END       = 8'd0;
  localparam logic [7:0]  BYTE_PAGE_SKIP = 8'd32;
  localparam logic [7:0]  BYTE_RELOC     = 8'd64;
  localparam logic [7:0]  EXT_LONG       = 8'd128;
  localparam logic [15:0] EXT_SHORT_BASE = 16'd43;
  localparam logic [15:0] EXT_LONG_BASE  = 16'd175;
  localparam logic [15:0] SKIP_BASE      = 16'd32;

  typedef struct packed {
    phase_t     phase;
    logic [6:0] ext_high;
    logic [4:0] skip_pages;
    logic       pending_low_bits;
  } parse_state_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] offset;
    logic [15:0] index;
    logic        low_bits;
  } reloc_t;

endpackage

`default_nettype wire

// File: src/rsd_decode.sv
`default_nettype none

module rsd_decode #(
  parameter int LOCATION_BITS = 16
) (
  input  wire logic [7:0]                 list_byte,
  input  wire rsd_pkg::parse_state_t      state,
  input  wire logic [LOCATION_BITS-1:0]   location,
  input  wire logic [15:0]                start_location,
  output rsd_pkg::parse_state_t           state_nxt,
  output logic [LOCATION_BITS-1:0]        location_nxt,
  output logic                            result_valid,
  output rsd_pkg::reloc_t                 result
);

  logic [5:0]               code;
  logic                     lowb;
  logic [15:0]              skip_amount;
  logic [LOCATION_BITS-1:0] loc_plus_two;

  assign code         = 6'(list_byte[7:2] - 6'd16);
  assign lowb         = |list_byte[1:0];
  assign skip_amount  = rsd_pkg::SKIP_BASE + {3'b0, state.skip_pages, 8'b0}
                        + {8'b0, list_byte};
  assign loc_plus_two = location + LOCATION_BITS'(2);

  always_comb begin
    state_nxt           = state;
    location_nxt        = location;
    result_valid        = 1'b0;
    result.kind         = rsd_pkg::KIND_END;
    result.offset       = location[15:0];
    result.index        = 16'd0;
    result.low_bits     = 1'b0;

    unique case (state.phase)
      rsd_pkg::PH_SKIP: begin
        location_nxt    = location + LOCATION_BITS'(skip_amount);
        state_nxt.phase = rsd_pkg::PH_CTRL;
      end
      rsd_pkg::PH_EXT1: begin
        if (list_byte < rsd_pkg::EXT_LONG) begin
          state_nxt.phase = rsd_pkg::PH_CTRL;
          result_valid    = 1'b1;
          result.kind     = rsd_pkg::KIND_SYMBOL;
          result.index    = rsd_pkg::EXT_SHORT_BASE + {9'b0, list_byte[6:0]};
          result.low_bits = state.pending_low_bits;
          location_nxt    = loc_plus_two;
        end else begin
          state_nxt.ext_high = list_byte[6:0];
          state_nxt.phase    = rsd_pkg::PH_EXT2;
        end
      end
      rsd_pkg::PH_EXT2: begin
        state_nxt.phase = rsd_pkg::PH_CTRL;
        result_valid    = 1'b1;
        result.kind     = rsd_pkg::KIND_SYMBOL;
        result.index    = {1'b0, state.ext_high, 8'b0} + rsd_pkg::EXT_LONG_BASE
                          + {8'b0, list_byte};
        result.low_bits = state.pending_low_bits;
        location_nxt    = loc_plus_two;
      end
      rsd_pkg::PH_CTRL: begin
        if (list_byte == rsd_pkg::BYTE_END) begin
          // End of list: report where we stopped, then reload the counter.
          result_valid = 1'b1;
          location_nxt = LOCATION_BITS'(start_location);
        end else if (list_byte < rsd_pkg::BYTE_PAGE_SKIP) begin
          location_nxt = location + LOCATION_BITS'(list_byte);
        end else if (list_byte < rsd_pkg::BYTE_RELOC) begin
          state_nxt.skip_pages = list_byte[4:0];
          state_nxt.phase      = rsd_pkg::PH_SKIP;
        end else begin
          result.low_bits = lowb;
          case (code) inside
            rsd_pkg::CODE_TEXT: begin
              result_valid = 1'b1;
              result.kind  = rsd_pkg::KIND_TEXT;
              location_nxt = loc_plus_two;
            end
            rsd_pkg::CODE_DATA: begin
              result_valid = 1'b1;
              result.kind  = rsd_pkg::KIND_DATA;
              location_nxt = loc_plus_two;
            end
            rsd_pkg::CODE_UNUSED_LO, rsd_pkg::CODE_UNUSED_HI: begin
              result_valid = 1'b1;
              result.kind  = rsd_pkg::KIND_UNUSED;
              location_nxt = loc_plus_two;
            end
            rsd_pkg::CODE_EXTENDED: begin
              state_nxt.pending_low_bits = lowb;
              state_nxt.phase            = rsd_pkg::PH_EXT1;
            end
            default: begin
              result_valid = 1'b1;
              result.kind  = rsd_pkg::KIND_SYMBOL;
              result.index = {10'b0, 6'(code - rsd_pkg::CODE_SYM_BASE)};
              location_nxt = loc_plus_two;
            end
          endcase
        end
      end
      default: begin
        state_nxt.phase = rsd_pkg::PH_CTRL;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: src/relocation_stream_decoder.sv
`default_nettype none
// Relocation list stream decoder.
// Input channel (in_valid / in_stall / in_list_byte) takes one byte of the
// relocation list per beat. Result channel (out_valid / out_stall / out_*)
// delivers one beat for each relocation, unused code or end-of-list marker;
// skip bytes, page-skip bytes and all bytes of an extended index but the last
// give no result. The configuration channel (cfg_valid / cfg_ready / cfg_data)
// writes the start location; cfg_ready is always high. The user must make writes
// only while the decoder is idle; the block itself does not enforce this.
// An accepted byte waits in the input register; the decode step writes its
// result to the result register, which drives the ports. One byte is accepted
// every cycle while out_stall does not hold a result; the single decode step
// between the input register and the result register sets that figure.
// Reset clears the start location and the location counter to zero and
// returns the parser to the control-byte phase.
// While out_stall holds a result, the decode step waits and in_stall rises
// once the input register is occupied; no beat is lost or repeated.
module relocation_stream_decoder #(
  parameter int LOCATION_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_list_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       out_reloc_kind,
  output logic [15:0]      out_reloc_offset,
  output logic [15:0]      out_symbol_index,
  output logic             out_low_bits_set,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] cfg_data
);

  logic                     in_valid_r;
  logic [7:0]               in_byte_r;
  logic                     out_valid_r;
  rsd_pkg::reloc_t          out_r;
  logic [15:0]              start_location_r;
  logic [LOCATION_BITS-1:0] location_r;
  rsd_pkg::parse_state_t    state_r;

  rsd_pkg::parse_state_t    state_nxt;
  logic [LOCATION_BITS-1:0] location_nxt;
  logic                     res_valid;
  rsd_pkg::reloc_t          res;
  logic                     advance;
  logic                     do_step;

  // The decode step runs when the result register is free or being emptied.
  assign advance  = !out_valid_r || !out_stall;
  assign do_step  = in_valid_r && advance;
  assign in_stall = in_valid_r && !advance;
  assign cfg_ready = 1'b1;

  rsd_decode #(
    .LOCATION_BITS(LOCATION_BITS)
  ) u_decode (
    .list_byte      (in_byte_r),
    .state          (state_r),
    .location       (location_r),
    .start_location (start_location_r),
    .state_nxt      (state_nxt),
    .location_nxt   (location_nxt),
    .result_valid   (res_valid),
    .result         (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r       <= 1'b0;
      out_valid_r      <= 1'b0;
      start_location_r <= 16'd0;
      location_r       <= '0;
      state_r          <= '{phase: rsd_pkg::PH_CTRL, ext_high: 7'd0,
                            skip_pages: 5'd0, pending_low_bits: 1'b0};
    end else begin
      if (cfg_valid && cfg_ready) begin
        start_location_r <= cfg_data;
      end
      if (!in_stall) begin
        in_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= do_step && res_valid;
      end
      if (do_step) begin
        location_r <= location_nxt;
        state_r    <= state_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_byte_r <= in_list_byte;
    end
    if (do_step && res_valid) begin
      out_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_reloc_kind   = out_r.kind;
  assign out_reloc_offset = out_r.offset;
  assign out_symbol_index = out_r.index;
  assign out_low_bits_set = out_r.low_bits;

  // An end-of-list byte reloads the counter from the start register.
  a_end_reload: assert property (@(posedge clk) disable iff (!rst_n)
    do_step && res_valid && res.kind == rsd_pkg::KIND_END
    |=> location_r == LOCATION_BITS'($past(start_location_r)))
    else $error("location not reloaded after end of list");

  // Only symbol relocations carry an index.
  a_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.kind != rsd_pkg::KIND_SYMBOL |-> out_r.index == 16'd0)
    else $error("non-symbol result with nonzero index");

  // The end marker never reports low bits.
  a_end_lowbits: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.kind == rsd_pkg::KIND_END |-> !out_r.low_bits)
    else $error("end of list with low bits set");

  // The byte after a page skip only moves the counter.
  a_skip_silent: assert property (@(posedge clk) disable iff (!rst_n)
    do_step && state_r.phase == rsd_pkg::PH_SKIP
    |=> state_r.phase == rsd_pkg::PH_CTRL && !(out_valid_r && !$past(out_valid_r)))
    else $error("page skip byte produced a result");

  // A result waiting under stall is not overwritten by a new decode.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |-> !do_step)
    else $error("decode step ran while result register was held");

endmodule

`default_nettype wire

// File: sim/rsd_checker.sv
module rsd_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  input  wire logic        in_stall,
  input  wire logic [7:0]  in_list_byte,
  input  wire logic        out_valid,
  input  wire logic        out_stall,
  input  wire logic [2:0]  out_reloc_kind,
  input  wire logic [15:0] out_reloc_offset,
  input  wire logic [15:0] out_symbol_index,
  input  wire logic        out_low_bits_set,
  input  wire logic        cfg_valid,
  input  wire logic        cfg_ready,
  input  wire logic [15:0] cfg_data,
  output int               fail_count,
  output int               open_count
);

  rsd_pkg::phase_t parse_phase;
  logic [15:0]     start_loc;
  logic [15:0]     location;
  logic [6:0]      ext_high;
  logic [4:0]      skip_pages;
  logic            pending_low;
  rsd_pkg::reloc_t reloc_q[$];

  task automatic report(input string msg);
    $display("%0t: relocation mismatch, %s", $time, msg);
    fail_count++;
  endtask

  // Queues a relocation at the current location; the counter then moves past the word.
  task automatic add_word_reloc(input logic [2:0] kind, input logic [15:0] index,
                                input logic low_bits);
    rsd_pkg::reloc_t r;
    r.kind = kind;
    r.offset = location;
    r.index = index;
    r.low_bits = low_bits;
    reloc_q.push_back(r);
    location = location + 16'd2;
  endtask

  task automatic decode_byte(input logic [7:0] b);
    logic [5:0]      code;
    logic            low_bits;
    rsd_pkg::reloc_t r;
    low_bits = |b[1:0];
    code = 6'((b - rsd_pkg::BYTE_RELOC) >> 2);
    case (parse_phase)
      rsd_pkg::PH_SKIP: begin
        location = location + rsd_pkg::SKIP_BASE + {3'b000, skip_pages, 8'h00}
                   + {8'h00, b};
        parse_phase = rsd_pkg::PH_CTRL;
      end
      rsd_pkg::PH_EXT1: begin
        if (b < rsd_pkg::EXT_LONG) begin
          parse_phase = rsd_pkg::PH_CTRL;
          add_word_reloc(rsd_pkg::KIND_SYMBOL, rsd_pkg::EXT_SHORT_BASE + {8'h00, b},
                         pending_low);
        end else begin
          ext_high = b[6:0];
          parse_phase = rsd_pkg::PH_EXT2;
        end
      end
      rsd_pkg::PH_EXT2: begin
        parse_phase = rsd_pkg::PH_CTRL;
        add_word_reloc(rsd_pkg::KIND_SYMBOL,
                       {1'b0, ext_high, 8'h00} + rsd_pkg::EXT_LONG_BASE + {8'h00, b},
                       pending_low);
      end
      default: begin
        if (b == rsd_pkg::BYTE_END) begin
          r.kind = rsd_pkg::KIND_END;
          r.offset = location;
          r.index = '0;
          r.low_bits = 1'b0;
          reloc_q.push_back(r);
          location = start_loc;
        end else if (b < rsd_pkg::BYTE_PAGE_SKIP) begin
          location = location + {8'h00, b};
        end else if (b < rsd_pkg::BYTE_RELOC) begin
          skip_pages = 5'(b - rsd_pkg::BYTE_PAGE_SKIP);
          parse_phase = rsd_pkg::PH_SKIP;
        end else begin
          case (code)
            rsd_pkg::CODE_TEXT: add_word_reloc(rsd_pkg::KIND_TEXT, '0, low_bits);
            rsd_pkg::CODE_DATA: add_word_reloc(rsd_pkg::KIND_DATA, '0, low_bits);
            rsd_pkg::CODE_UNUSED_LO, rsd_pkg::CODE_UNUSED_HI:
              add_word_reloc(rsd_pkg::KIND_UNUSED, '0, low_bits);
            rsd_pkg::CODE_EXTENDED: begin
              pending_low = low_bits;
              parse_phase = rsd_pkg::PH_EXT1;
            end
            default: add_word_reloc(rsd_pkg::KIND_SYMBOL,
                                    16'(code - rsd_pkg::CODE_SYM_BASE), low_bits);
          endcase
        end
      end
    endcase
  endtask

  always @(posedge clk) begin
    rsd_pkg::reloc_t want;
    if (!rst_n) begin
      parse_phase = rsd_pkg::PH_CTRL;
      start_loc = '0;
      location = '0;
      ext_high = '0;
      skip_pages = '0;
      pending_low = 1'b0;
      reloc_q.delete();
    end else begin
      // A result leaving at this edge can only belong to a byte taken at an earlier edge.
      if (out_valid && !out_stall) begin
        if (reloc_q.size() == 0) begin
          report($sformatf("result with none expected: kind %0d offset %0h",
                           out_reloc_kind, out_reloc_offset));
        end else begin
          want = reloc_q.pop_front();
          if (out_reloc_kind !== want.kind)
            report($sformatf("kind: expected %0d, got %0d", want.kind, out_reloc_kind));
          if (out_reloc_offset !== want.offset)
            report($sformatf("offset: expected %0h, got %0h", want.offset, out_reloc_offset));
          if (out_symbol_index !== want.index)
            report($sformatf("symbol index: expected %0d, got %0d", want.index,
                             out_symbol_index));
          if (out_low_bits_set !== want.low_bits)
            report($sformatf("low bits flag: expected %0b, got %0b", want.low_bits,
                             out_low_bits_set));
        end
      end
      if (in_valid && !in_stall)
        decode_byte(in_list_byte);
      if (cfg_valid && cfg_ready)
        start_loc = cfg_data;
    end
    open_count = reloc_q.size();
  end

endmodule

// File: sim/tb_relocation_stream_decoder.sv
module tb_relocation_stream_decoder;

  localparam int STALL_LIMIT = 2000;
  localparam int PHASE_BYTES = 250;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_list_byte;
  logic        out_valid;
  logic        out_stall;
  logic [2:0]  out_reloc_kind;
  logic [15:0] out_reloc_offset;
  logic [15:0] out_symbol_index;
  logic        out_low_bits_set;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] cfg_data;
  int          fail_count;
  int          open_count;
  int          bytes_sent;
  int          stalled_cycles;
  logic        no_gaps;
  logic [7:0]  directed_bytes [0:26];

  relocation_stream_decoder i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_list_byte     (in_list_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_reloc_kind   (out_reloc_kind),
    .out_reloc_offset (out_reloc_offset),
    .out_symbol_index (out_symbol_index),
    .out_low_bits_set (out_low_bits_set),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data)
  );

  rsd_checker i_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_list_byte     (in_list_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_reloc_kind   (out_reloc_kind),
    .out_reloc_offset (out_reloc_offset),
    .out_symbol_index (out_symbol_index),
    .out_low_bits_set (out_low_bits_set),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data),
    .fail_count       (fail_count),
    .open_count       (open_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The result side stalls at random unless the gap-free stretch is running.
  always @(negedge clk) begin
    out_stall = !no_gaps && ($urandom_range(0, 99) < 22);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      stalled_cycles <= 0;
    end else begin
      stalled_cycles <= stalled_cycles + 1;
      if (stalled_cycles >= STALL_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // Offers one byte and holds it until the decoder takes the beat.
  task automatic send_byte(input logic [7:0] b);
    while (!no_gaps && ($urandom_range(0, 99) < 22)) begin
      in_valid = 1'b0;
      in_list_byte = 8'($urandom);
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_list_byte = b;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
    @(negedge clk);
  endtask

  // Mostly well-formed records with random content, plus some raw noise bytes.
  task automatic send_record();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      send_byte(8'($urandom_range(64, 251)));
    end else if (pick < 52) begin
      send_byte(8'($urandom_range(252, 255)));
      if ($urandom_range(0, 1) == 0) begin
        send_byte(8'($urandom_range(0, 127)));
      end else begin
        send_byte(8'($urandom_range(128, 255)));
        send_byte(8'($urandom_range(0, 255)));
      end
    end else if (pick < 65) begin
      send_byte(8'($urandom_range(1, 31)));
    end else if (pick < 77) begin
      send_byte(8'($urandom_range(32, 63)));
      send_byte(8'($urandom_range(0, 255)));
    end else if (pick < 85) begin
      send_byte(8'd0);
    end else begin
      send_byte(8'($urandom_range(0, 255)));
    end
  endtask

  // Lets every expected result drain, then waits out the settle time for a byte still in flight.
  task automatic drain(input int settle);
    in_valid = 1'b0;
    while (open_count != 0) @(negedge clk);
    repeat (settle) @(negedge clk);
  endtask

  task automatic write_start_location(input logic [15:0] value);
    cfg_valid = 1'b1;
    cfg_data = value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  initial begin
    logic [15:0] phase_start [0:3];
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_list_byte = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    no_gaps = 1'b0;
    stalled_cycles = 0;
    bytes_sent = 0;
    // End markers, both skip forms, every relocation code group, extended index
    // extremes, and a text relocation at the top of the address space.
    directed_bytes = '{8'd0, 8'd68, 8'd1, 8'd31, 8'd32, 8'd0, 8'd63, 8'd255, 8'd64,
                       8'd67, 8'd71, 8'd72, 8'd75, 8'd76, 8'd79, 8'd80, 8'd251,
                       8'd252, 8'd0, 8'd252, 8'd127, 8'd255, 8'd128, 8'd0, 8'd252,
                       8'd255, 8'd255};
    phase_start = '{16'h0000, 16'($urandom), 16'hFFFE, 16'($urandom)};
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    write_start_location(16'hFFFF);
    foreach (directed_bytes[i]) send_byte(directed_bytes[i]);
    send_byte(8'd0);

    for (int p = 0; p < 4; p++) begin
      drain(4);
      write_start_location(phase_start[p]);
      no_gaps = (p == 2);
      while (bytes_sent < (p + 1) * PHASE_BYTES + 28) send_record();
    end
    no_gaps = 1'b0;

    drain(8);
    if (fail_count == 0 && open_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
